FILE: rtl/als_pkg.sv
// Shared types, constants and helpers for the alarm siren sequencer.
// No dependencies; every other file of the block imports this package.
package als_pkg;

    localparam int ANOMALY_LIMIT = 2;
    localparam int RECHECK_COUNT = 10;
    localparam int LINE_COUNT    = 4;

    localparam int TIME_W    = 40;
    localparam int DUR_W     = 24;
    localparam int SMALL_W   = 4;
    localparam int SAMPLE_W  = 4;
    localparam int RECHECK_W = 40;
    localparam int CFG_DATA_W = DUR_W;

    // shared subtractor width
    localparam int SUB_W = TIME_W;

    // recheck scan counters
    localparam int IDX_W = $clog2(RECHECK_COUNT + 1);
    localparam int CNT_W = $clog2(RECHECK_COUNT + ANOMALY_LIMIT + 1);

    localparam logic [SAMPLE_W-1:0] LINE_SEL = SAMPLE_W'((1 << LINE_COUNT) - 1);

    localparam logic [DUR_W-1:0]   RING_TIME_RST   = DUR_W'(120000);
    localparam logic [DUR_W-1:0]   SHORT_PAUSE_RST = DUR_W'(30000);
    localparam logic [DUR_W-1:0]   LONG_PAUSE_RST  = DUR_W'(180000);
    localparam logic [DUR_W-1:0]   AUTO_REC_RST    = DUR_W'(1800000);
    localparam logic [SMALL_W-1:0] GROUP_RST       = SMALL_W'(2);
    localparam logic [SMALL_W-1:0] MAX_RINGS_RST   = SMALL_W'(6);
    localparam logic [SMALL_W-1:0] MASK_RST        = SMALL_W'(15);
    localparam logic [SMALL_W-1:0] PATTERN_RST     = SMALL_W'(0);

    typedef enum logic [3:0] {
        OP_TICK        = 4'd0,
        OP_ENABLE      = 4'd1,
        OP_DISABLE     = 4'd2,
        OP_RECOVER     = 4'd3,
        OP_MODE_NORMAL = 4'd4,
        OP_MODE_SILENT = 4'd5,
        OP_TEST_ON     = 4'd6,
        OP_TEST_OFF    = 4'd7,
        OP_TEST_TOGGLE = 4'd8
    } t_op;

    typedef enum logic [2:0] {
        CFG_RING_TIME   = 3'd0,
        CFG_SHORT_PAUSE = 3'd1,
        CFG_LONG_PAUSE  = 3'd2,
        CFG_AUTO_REC    = 3'd3,
        CFG_GROUP_SIZE  = 3'd4,
        CFG_MAX_RINGS   = 3'd5,
        CFG_LINE_MASK   = 3'd6,
        CFG_LINE_PAT    = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        AL_INACTIVE   = 2'd0,
        AL_OBSERVING  = 2'd1,
        AL_SOUNDING   = 2'd2,
        AL_RECOVERING = 2'd3
    } t_alarm;

    typedef enum logic [1:0] {
        SP_INIT       = 2'd0,
        SP_RINGING    = 2'd1,
        SP_WAITING    = 2'd2,
        SP_TERMINATED = 2'd3
    } t_siren;

    typedef enum logic [1:0] {
        LT_NONE = 2'd0,
        LT_ON   = 2'd1,
        LT_OFF  = 2'd2
    } t_light;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMD,
        ST_SCAN,
        ST_PASS,
        ST_SIREN,
        ST_ELAPSED,
        ST_COMPARE,
        ST_MOD,
        ST_POST,
        ST_RECOVER,
        ST_DONE
    } t_seq;

    typedef struct packed {
        logic [3:0]           opcode;
        logic [TIME_W-1:0]    now_ms;
        logic [SAMPLE_W-1:0]  first_sample;
        logic [RECHECK_W-1:0] recheck_samples;
    } t_in_item;

    typedef struct packed {
        logic       siren_on;
        logic [1:0] light_cmd;
        logic [1:0] alarm_stage;
        logic [1:0] siren_phase;
        logic       armed;
        logic       silent;
        logic       telemetry_pulse;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic good;
    } t_scan_stat;

    function automatic logic sample_ok(
        input logic [SAMPLE_W-1:0] s,
        input logic [SAMPLE_W-1:0] mask,
        input logic [SAMPLE_W-1:0] pattern
    );
        return ((s & mask & LINE_SEL) == pattern);
    endfunction

endpackage

FILE: rtl/als_if.sv
// Valid/ready stream interfaces for the input and result channels.
// Depends on als_pkg for the payload structs.
interface als_in_if;
    import als_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface als_out_if;
    import als_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/als_sub.sv
// Shared 40-bit subtractor with borrow out: elapsed time, threshold
// compare and the ring group remainder all go through it. Uses als_pkg.
module als_sub (
    input  logic [als_pkg::SUB_W-1:0] i_a,
    input  logic [als_pkg::SUB_W-1:0] i_b,
    output logic [als_pkg::SUB_W-1:0] o_diff,
    output logic                      o_borrow
);
    import als_pkg::*;

    logic [SUB_W:0] w_full;

    assign w_full   = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = w_full[SUB_W-1:0];
    assign o_borrow = w_full[SUB_W];

endmodule

FILE: rtl/als_scan.sv
// Line check: walks the recheck samples one per cycle counting failures, and
// at the end tests the first sample too. Uses als_pkg for widths and sample_ok.
module als_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [als_pkg::SAMPLE_W-1:0]  i_first,
    input  logic [als_pkg::RECHECK_W-1:0] i_recheck,
    input  logic [als_pkg::SAMPLE_W-1:0]  i_mask,
    input  logic [als_pkg::SAMPLE_W-1:0]  i_pattern,
    output als_pkg::t_scan_stat           o_stat
);
    import als_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(RECHECK_COUNT - 1);
    localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(ANOMALY_LIMIT);

    logic                 r_busy;
    logic                 r_good;
    logic [IDX_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_bad;
    logic [RECHECK_W-1:0] w_shifted;
    logic [SAMPLE_W-1:0]  w_sample;
    logic [CNT_W-1:0]     w_bad_next;
    logic                 w_last;

    // samples past the top of the field shift in as zero
    assign w_shifted  = i_recheck >> {r_idx, 2'b00};
    assign w_sample   = w_shifted[SAMPLE_W-1:0];
    assign w_bad_next = r_bad + CNT_W'(!sample_ok(w_sample, i_mask, i_pattern));
    assign w_last     = (r_idx == LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && w_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx <= '0;
            r_bad <= '0;
        end else if (r_busy) begin
            r_idx <= r_idx + IDX_W'(1);
            r_bad <= w_bad_next;
            if (w_last) begin
                r_good <= sample_ok(i_first, i_mask, i_pattern) ||
                          (w_bad_next <= LIMIT_CNT);
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.good = r_good;

endmodule

FILE: rtl/alarm_siren_sequencer.sv
// Top level of the alarm siren sequencer: config registers, sequencer,
// alarm/siren state and output register. Uses als_pkg, als_if, als_sub, als_scan.
//
//  channel   dir  handshake            beat
//  i_in      in   valid/ready          opcode, now_ms, first_sample, recheck_samples
//  o_out     out  valid/ready          siren_on .. telemetry_pulse
//  i_cfg_*   in   write enable only    register index, 24-bit data
//
// Siren test commands go from decode straight to the output register. Every other
// beat also runs the line scan, which walks one recheck sample a cycle; each time
// compare costs two passes through the shared subtractor, and the ring group
// remainder is one subtraction a cycle until the borrow.
// i_in.ready is high only in the idle state; a finished beat waits in the
// output register, so one more item can be taken before o_out is drained.
// Reset is synchronous; it restores control state and config defaults only.
module alarm_siren_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  als_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [als_pkg::CFG_DATA_W-1:0] i_cfg_data,
    als_in_if.sink                         i_in,
    als_out_if.source                      o_out
);
    import als_pkg::*;

    // configuration
    logic [DUR_W-1:0]   r_ring_time;
    logic [DUR_W-1:0]   r_short_pause;
    logic [DUR_W-1:0]   r_long_pause;
    logic [DUR_W-1:0]   r_auto_rec;
    logic [SMALL_W-1:0] r_group;
    logic [SMALL_W-1:0] r_max_rings;
    logic [SMALL_W-1:0] r_mask;
    logic [SMALL_W-1:0] r_pattern;

    // latched beat
    t_op                  r_op;
    logic [TIME_W-1:0]    r_now;
    logic [SAMPLE_W-1:0]  r_first;
    logic [RECHECK_W-1:0] r_recheck;

    // sequencer and alarm state
    t_seq               r_state, n_state;
    t_alarm             r_alarm, n_alarm;
    t_siren             r_siren, n_siren;
    logic [SMALL_W-1:0] r_ring, n_ring;
    logic               r_long_sel, n_long_sel;
    logic [TIME_W-1:0]  r_marker, n_marker;
    logic [TIME_W-1:0]  r_rec_start, n_rec_start;
    logic               r_enabled, n_enabled;
    logic               r_silent, n_silent;
    logic               r_relay, n_relay;
    logic               r_rec_pend, n_rec_pend;
    t_light             r_light, n_light;
    logic               r_pulse, n_pulse;
    logic [TIME_W-1:0]  r_el, n_el;
    logic [SMALL_W-1:0] r_rem, n_rem;

    // output register
    logic      r_out_valid;
    t_out_item r_out;

    logic               w_in_fire;
    logic               w_out_load;
    logic [SUB_W-1:0]   w_sub_a;
    logic [SUB_W-1:0]   w_sub_b;
    logic [SUB_W-1:0]   w_sub_diff;
    logic               w_sub_borrow;
    logic [DUR_W-1:0]   w_thr;
    logic [SMALL_W-1:0] w_group;
    logic [SMALL_W-1:0] w_ring_inc;
    t_scan_stat         w_scan;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign w_out_load  = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);
    assign w_group     = (r_group == '0) ? SMALL_W'(1) : r_group;
    assign w_ring_inc  = r_ring + SMALL_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_time   <= RING_TIME_RST;
            r_short_pause <= SHORT_PAUSE_RST;
            r_long_pause  <= LONG_PAUSE_RST;
            r_auto_rec    <= AUTO_REC_RST;
            r_group       <= GROUP_RST;
            r_max_rings   <= MAX_RINGS_RST;
            r_mask        <= MASK_RST;
            r_pattern     <= PATTERN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RING_TIME:   r_ring_time   <= i_cfg_data;
                CFG_SHORT_PAUSE: r_short_pause <= i_cfg_data;
                CFG_LONG_PAUSE:  r_long_pause  <= i_cfg_data;
                CFG_AUTO_REC:    r_auto_rec    <= i_cfg_data;
                CFG_GROUP_SIZE:  r_group       <= i_cfg_data[SMALL_W-1:0];
                CFG_MAX_RINGS:   r_max_rings   <= i_cfg_data[SMALL_W-1:0];
                CFG_LINE_MASK:   r_mask        <= i_cfg_data[SMALL_W-1:0];
                CFG_LINE_PAT:    r_pattern     <= i_cfg_data[SMALL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op      <= t_op'(i_in.data.opcode);
            r_now     <= i_in.data.now_ms;
            r_first   <= i_in.data.first_sample;
            r_recheck <= i_in.data.recheck_samples;
        end
    end

    als_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_in_fire),
        .i_first   (r_first),
        .i_recheck (r_recheck),
        .i_mask    (r_mask),
        .i_pattern (r_pattern),
        .o_stat    (w_scan)
    );

    // operand select for the shared subtractor
    always_comb begin
        if (r_alarm == AL_RECOVERING) begin
            w_thr = r_auto_rec;
        end else if (r_siren == SP_RINGING) begin
            w_thr = r_ring_time;
        end else begin
            w_thr = r_long_sel ? r_long_pause : r_short_pause;
        end

        w_sub_a = r_now;
        w_sub_b = (r_alarm == AL_RECOVERING) ? r_rec_start : r_marker;
        case (r_state)
            ST_COMPARE: begin
                // borrow set means elapsed > threshold
                w_sub_a = SUB_W'(w_thr);
                w_sub_b = r_el;
            end
            ST_MOD: begin
                w_sub_a = SUB_W'(r_rem);
                w_sub_b = SUB_W'(w_group);
            end
            default: ;
        endcase
    end

    als_sub u_sub (
        .i_a      (w_sub_a),
        .i_b      (w_sub_b),
        .o_diff   (w_sub_diff),
        .o_borrow (w_sub_borrow)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_alarm     <= AL_INACTIVE;
            r_siren     <= SP_INIT;
            r_ring      <= '0;
            r_long_sel  <= 1'b0;
            r_marker    <= '0;
            r_rec_start <= '0;
            r_enabled   <= 1'b0;
            r_silent    <= 1'b0;
            r_relay     <= 1'b0;
            r_rec_pend  <= 1'b0;
            r_light     <= LT_NONE;
            r_pulse     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_alarm     <= n_alarm;
            r_siren     <= n_siren;
            r_ring      <= n_ring;
            r_long_sel  <= n_long_sel;
            r_marker    <= n_marker;
            r_rec_start <= n_rec_start;
            r_enabled   <= n_enabled;
            r_silent    <= n_silent;
            r_relay     <= n_relay;
            r_rec_pend  <= n_rec_pend;
            r_light     <= n_light;
            r_pulse     <= n_pulse;
        end
    end

    always_ff @(posedge i_clk) begin
        r_el  <= n_el;
        r_rem <= n_rem;
    end

    always_comb begin
        n_state     = r_state;
        n_alarm     = r_alarm;
        n_siren     = r_siren;
        n_ring      = r_ring;
        n_long_sel  = r_long_sel;
        n_marker    = r_marker;
        n_rec_start = r_rec_start;
        n_enabled   = r_enabled;
        n_silent    = r_silent;
        n_relay     = r_relay;
        n_rec_pend  = r_rec_pend;
        n_light     = r_light;
        n_pulse     = r_pulse;
        n_el        = r_el;
        n_rem       = r_rem;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_light = LT_NONE;
                    n_pulse = 1'b0;
                    n_state = ST_CMD;
                end
            end
            ST_CMD: begin
                n_state = ST_SCAN;
                unique case (r_op)
                    OP_ENABLE:  n_enabled = 1'b1;
                    OP_DISABLE: n_enabled = 1'b0;
                    OP_RECOVER: begin
                        if (r_alarm == AL_RECOVERING) begin
                            n_rec_pend = 1'b1;
                        end
                    end
                    OP_MODE_NORMAL: begin
                        if (r_silent) begin
                            n_alarm  = AL_INACTIVE;
                            n_relay  = 1'b0;
                            n_ring   = '0;
                            n_siren  = SP_INIT;
                            n_silent = 1'b0;
                        end
                    end
                    OP_MODE_SILENT: begin
                        if (!r_silent) begin
                            n_relay  = 1'b0;
                            n_silent = 1'b1;
                        end
                    end
                    OP_TEST_ON: begin
                        n_state = ST_DONE;
                        if (r_alarm == AL_INACTIVE && !r_silent) begin
                            n_relay = 1'b1;
                        end
                    end
                    OP_TEST_OFF: begin
                        n_state = ST_DONE;
                        if (r_alarm == AL_INACTIVE && !r_silent) begin
                            n_relay = 1'b0;
                        end
                    end
                    OP_TEST_TOGGLE: begin
                        n_state = ST_DONE;
                        if (r_alarm == AL_INACTIVE && !r_silent) begin
                            n_relay = !r_relay;
                        end
                    end
                    default: ; // tick and unused codes
                endcase
            end
            ST_SCAN: begin
                if (!w_scan.busy) begin
                    n_state = ST_PASS;
                end
            end
            ST_PASS: begin
                n_state = ST_DONE;
                if (r_alarm != AL_INACTIVE && !r_enabled) begin
                    // dropped out by disable: no telemetry
                    n_alarm = AL_INACTIVE;
                    n_relay = 1'b0;
                    n_ring  = '0;
                    n_siren = SP_INIT;
                end else begin
                    unique case (r_alarm)
                        AL_INACTIVE: begin
                            if (r_enabled) begin
                                if (w_scan.good) begin
                                    n_relay = 1'b0;
                                    n_ring  = '0;
                                    n_siren = SP_INIT;
                                    n_alarm = AL_OBSERVING;
                                    n_pulse = 1'b1;
                                end else begin
                                    n_enabled = 1'b0;
                                end
                            end
                        end
                        AL_OBSERVING: begin
                            if (!w_scan.good) begin
                                n_light = LT_ON;
                                n_alarm = AL_SOUNDING;
                                n_pulse = 1'b1;
                                n_state = ST_SIREN;
                            end
                        end
                        AL_SOUNDING: n_state = ST_SIREN;
                        AL_RECOVERING: begin
                            n_state = r_rec_pend ? ST_RECOVER : ST_ELAPSED;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SIREN: begin
                unique case (r_siren)
                    SP_INIT: begin
                        n_ring   = '0;
                        n_marker = r_now;
                        if (!r_silent) begin
                            n_relay = 1'b1;
                        end
                        n_pulse = 1'b1;
                        n_siren = SP_RINGING;
                        n_state = ST_POST;
                    end
                    SP_RINGING, SP_WAITING: n_state = ST_ELAPSED;
                    default: n_state = ST_POST;
                endcase
            end
            ST_ELAPSED: begin
                n_el    = w_sub_diff;
                n_state = ST_COMPARE;
            end
            ST_COMPARE: begin
                if (r_alarm == AL_RECOVERING) begin
                    n_state = w_sub_borrow ? ST_RECOVER : ST_DONE;
                end else begin
                    n_state = ST_POST;
                    if (w_sub_borrow) begin
                        n_marker = r_now;
                        if (r_siren == SP_RINGING) begin
                            n_ring = w_ring_inc;
                            if (w_ring_inc < r_max_rings) begin
                                n_rem   = w_ring_inc;
                                n_state = ST_MOD;
                            end else begin
                                if (!r_silent) begin
                                    n_relay = 1'b0;
                                end
                                n_pulse = 1'b1;
                                n_siren = SP_TERMINATED;
                            end
                        end else begin
                            if (!r_silent) begin
                                n_relay = 1'b1;
                            end
                            n_pulse = 1'b1;
                            n_siren = SP_RINGING;
                        end
                    end
                end
            end
            ST_MOD: begin
                // remainder by repeated subtraction of the group size
                if (w_sub_borrow) begin
                    n_long_sel = (r_rem == '0);
                    if (!r_silent) begin
                        n_relay = 1'b0;
                    end
                    n_pulse = 1'b1;
                    n_siren = SP_WAITING;
                    n_state = ST_POST;
                end else begin
                    n_rem = w_sub_diff[SMALL_W-1:0];
                end
            end
            ST_POST: begin
                n_state = ST_DONE;
                if (r_siren == SP_WAITING && w_scan.good) begin
                    n_light = LT_OFF;
                    n_alarm = AL_OBSERVING;
                    n_pulse = 1'b1;
                end else if (r_siren == SP_TERMINATED) begin
                    n_rec_start = r_now;
                    n_alarm     = AL_RECOVERING;
                    n_pulse     = 1'b1;
                end
            end
            ST_RECOVER: begin
                n_rec_pend = 1'b0;
                n_relay    = 1'b0;
                n_ring     = '0;
                n_siren    = SP_INIT;
                n_light    = LT_OFF;
                n_alarm    = w_scan.good ? AL_OBSERVING : AL_INACTIVE;
                n_pulse    = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.siren_on        <= r_relay;
            r_out.light_cmd       <= r_light;
            r_out.alarm_stage     <= r_alarm;
            r_out.siren_phase     <= r_siren;
            r_out.armed           <= r_enabled;
            r_out.silent          <= r_silent;
            r_out.telemetry_pulse <= r_pulse;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // an accepted beat always goes to command decode next
    a_accept_to_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_state == ST_CMD))
        else $error("accepted beat did not enter command decode");

    // the alarm pass must not run on a stale line check
    a_scan_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PASS) |-> !w_scan.busy)
        else $error("alarm pass ran while line scan busy");

    // every way into inactive also clears the siren sequence
    a_inactive_siren: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_alarm == AL_INACTIVE) |-> (r_siren == SP_INIT))
        else $error("siren phase left set while alarm inactive");

    // silent mode never lets the relay turn on
    a_silent_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_relay) |-> !$past(r_silent))
        else $error("relay turned on in silent mode");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for alarm_siren_sequencer: directed and random command/tick beats.
// It predicts every result beat in-line and compares each one field by field.
// Depends on rtl/als_pkg.sv, rtl/als_if.sv and the RTL of the block.
module tb_top;
    import als_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int TIMEOUT_NS  = 5_000_000;
    localparam logic [3:0] OP_UNUSED_LO = 4'd9;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    t_cfg_idx cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    als_in_if  in_if ();
    als_out_if out_if ();

    alarm_siren_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ---------------- predictor state and register copy ----------------
    logic [DUR_W-1:0]   ring_ms, short_ms, long_ms, autorec_ms;
    logic [SMALL_W-1:0] group_sz, ring_limit, watch_mask, watch_pat;

    t_alarm            al_state;
    t_siren            sr_phase;
    logic [3:0]        ring_cnt;
    logic              long_sel;
    logic [TIME_W-1:0] phase_t0, recover_t0;
    logic              armed_q, silent_q, relay_q, recover_req;

    t_light   light_now;
    logic     pulse_now;
    t_in_item cur;

    t_out_item expected_beats[$];
    int        mismatch_count = 0;

    // stimulus state
    logic [TIME_W-1:0] clock_ms;
    logic              intrusion;
    int                step_max;
    int                hold_token = 0;
    int                hold_len = 0;

    function automatic logic sample_fine(logic [SAMPLE_W-1:0] s);
        return (s & watch_mask) == watch_pat;
    endfunction

    function automatic logic lines_fine();
        int misses;
        misses = 0;
        if (sample_fine(cur.first_sample))
            return 1'b1;
        for (int i = 0; i < RECHECK_COUNT; i++)
            if (!sample_fine(cur.recheck_samples[4*i +: 4]))
                misses++;
        return misses <= ANOMALY_LIMIT;
    endfunction

    // silent mode freezes the relay except for a full clear
    function automatic void relay_drive(logic level);
        if (!silent_q)
            relay_q = level;
    endfunction

    function automatic void siren_clear();
        relay_q = 1'b0;
        ring_cnt = '0;
        sr_phase = SP_INIT;
    endfunction

    function automatic void move_alarm(t_alarm next);
        if (next != al_state) begin
            al_state = next;
            pulse_now = 1'b1;
        end
    endfunction

    function automatic void move_siren(t_siren next);
        if (next != sr_phase) begin
            relay_drive(next == SP_RINGING);
            pulse_now = 1'b1;
            sr_phase = next;
        end
    endfunction

    function automatic void siren_advance();
        logic [TIME_W-1:0] elapsed;
        logic [3:0]        grp;
        elapsed = cur.now_ms - phase_t0;
        case (sr_phase)
            SP_INIT: begin
                ring_cnt = '0;
                phase_t0 = cur.now_ms;
                move_siren(SP_RINGING);
            end
            SP_RINGING: begin
                if (elapsed > {16'd0, ring_ms}) begin
                    grp = (group_sz == 0) ? 4'd1 : group_sz;
                    phase_t0 = cur.now_ms;
                    ring_cnt = ring_cnt + 4'd1;
                    if (ring_cnt < ring_limit) begin
                        long_sel = (ring_cnt % grp) == 0;
                        move_siren(SP_WAITING);
                    end else begin
                        move_siren(SP_TERMINATED);
                    end
                end
            end
            SP_WAITING: begin
                if (elapsed > {16'd0, (long_sel ? long_ms : short_ms)}) begin
                    phase_t0 = cur.now_ms;
                    move_siren(SP_RINGING);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void alarm_advance();
        if (al_state != AL_INACTIVE && !armed_q) begin
            al_state = AL_INACTIVE;
            siren_clear();
        end
        case (al_state)
            AL_INACTIVE: begin
                if (armed_q) begin
                    if (lines_fine()) begin
                        siren_clear();
                        move_alarm(AL_OBSERVING);
                    end else begin
                        armed_q = 1'b0;
                    end
                end
            end
            AL_OBSERVING, AL_SOUNDING: begin
                if (!(al_state == AL_OBSERVING && lines_fine())) begin
                    if (al_state == AL_OBSERVING) begin
                        light_now = LT_ON;
                        move_alarm(AL_SOUNDING);
                    end
                    siren_advance();
                    if (sr_phase == SP_WAITING && lines_fine()) begin
                        light_now = LT_OFF;
                        move_alarm(AL_OBSERVING);
                    end else if (sr_phase == SP_TERMINATED) begin
                        recover_t0 = cur.now_ms;
                        move_alarm(AL_RECOVERING);
                    end
                end
            end
            default: begin
                if (recover_req || (cur.now_ms - recover_t0) > {16'd0, autorec_ms}) begin
                    recover_req = 1'b0;
                    siren_clear();
                    light_now = LT_OFF;
                    move_alarm(lines_fine() ? AL_OBSERVING : AL_INACTIVE);
                end
            end
        endcase
    endfunction

    function automatic t_out_item predict_beat(t_in_item beat);
        logic      run_pass;
        t_out_item res;
        cur = beat;
        light_now = LT_NONE;
        pulse_now = 1'b0;
        run_pass = 1'b1;
        case (beat.opcode)
            OP_ENABLE:  armed_q = 1'b1;
            OP_DISABLE: armed_q = 1'b0;
            OP_RECOVER: if (al_state == AL_RECOVERING) recover_req = 1'b1;
            OP_MODE_NORMAL: begin
                // leaving silent mode resets without telemetry
                if (silent_q) begin
                    al_state = AL_INACTIVE;
                    siren_clear();
                    silent_q = 1'b0;
                end
            end
            OP_MODE_SILENT: begin
                if (!silent_q) begin
                    relay_drive(1'b0);
                    silent_q = 1'b1;
                end
            end
            OP_TEST_ON: begin
                run_pass = 1'b0;
                if (al_state == AL_INACTIVE) relay_drive(1'b1);
            end
            OP_TEST_OFF: begin
                run_pass = 1'b0;
                if (al_state == AL_INACTIVE) relay_drive(1'b0);
            end
            OP_TEST_TOGGLE: begin
                run_pass = 1'b0;
                if (al_state == AL_INACTIVE) relay_drive(!relay_q);
            end
            default: ;
        endcase
        if (run_pass)
            alarm_advance();
        res.siren_on        = relay_q;
        res.light_cmd       = light_now;
        res.alarm_stage     = al_state;
        res.siren_phase     = sr_phase;
        res.armed           = armed_q;
        res.silent          = silent_q;
        res.telemetry_pulse = pulse_now;
        return res;
    endfunction

    // ---------------- result checking ----------------
    function automatic void check_field(string fname, logic [3:0] want, logic [3:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, fname, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (expected_beats.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: result beat expected none, got %p", $time, out_if.data);
            end else begin
                want = expected_beats.pop_front();
                check_field("siren_on", want.siren_on, out_if.data.siren_on);
                check_field("light_cmd", want.light_cmd, out_if.data.light_cmd);
                check_field("alarm_stage", want.alarm_stage, out_if.data.alarm_stage);
                check_field("siren_phase", want.siren_phase, out_if.data.siren_phase);
                check_field("armed", want.armed, out_if.data.armed);
                check_field("silent", want.silent, out_if.data.silent);
                check_field("telemetry_pulse", want.telemetry_pulse,
                            out_if.data.telemetry_pulse);
            end
        end
    end

    // ---------------- result side: stall patterns and long hold-offs ----------------
    initial begin
        int          pat_left;
        int          bitpos;
        int          hold_left;
        int          hold_seen;
        logic [15:0] pat;
        out_if.ready = 1'b0;
        pat_left = 0;
        bitpos = 0;
        hold_left = 0;
        hold_seen = 0;
        pat = '1;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_token) begin
                hold_seen = hold_token;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                if (pat_left == 0) begin
                    pat_left = $urandom_range(16, 96);
                    case ($urandom_range(0, 3))
                        0: pat = '1;
                        1: pat = 16'($urandom);
                        2: pat = 16'($urandom | $urandom);
                        default: pat = 16'($urandom & $urandom);
                    endcase
                    if (pat == 0)
                        pat = 16'h0001;
                end
                pat_left--;
                out_if.ready <= pat[bitpos];
                bitpos = (bitpos + 1) % 16;
            end
        end
    end

    // ---------------- stimulus helpers ----------------
    function automatic logic [SAMPLE_W-1:0] fine_sample();
        return watch_pat | (4'($urandom) & ~watch_mask);
    endfunction

    function automatic logic [SAMPLE_W-1:0] faulty_sample();
        logic [SAMPLE_W-1:0] s;
        int                  b;
        s = fine_sample();
        if (watch_mask == 0)
            return 4'($urandom);
        do b = $urandom_range(0, 3); while (!watch_mask[b]);
        s[b] = !s[b];
        return s;
    endfunction

    // exactly `misses` of the recheck samples fail, at random positions
    function automatic t_in_item build_beat(logic [3:0] op, logic first_good, int misses);
        t_in_item b;
        int       need;
        need = misses;
        b.opcode = op;
        b.now_ms = clock_ms;
        b.first_sample = first_good ? fine_sample() : faulty_sample();
        for (int i = 0; i < RECHECK_COUNT; i++) begin
            if (int'($urandom_range(0, RECHECK_COUNT - 1 - i)) < need) begin
                b.recheck_samples[4*i +: 4] = faulty_sample();
                need--;
            end else begin
                b.recheck_samples[4*i +: 4] = fine_sample();
            end
        end
        return b;
    endfunction

    function automatic t_in_item random_beat();
        t_in_item   b;
        int         pick;
        logic [3:0] op;
        // intrusion episodes keep the lines bad long enough to reach the later rings
        if ($urandom_range(0, 19) == 0)
            intrusion = !intrusion;
        if ($urandom_range(0, 32) == 0)
            clock_ms = clock_ms + TIME_W'($urandom_range(0, step_max * 16));
        else
            clock_ms = clock_ms + TIME_W'($urandom_range(0, step_max));
        pick = $urandom_range(0, 99);
        op = OP_TICK;
        if (!armed_q && pick < 40)
            op = OP_ENABLE;
        else if (pick < 2)
            op = OP_DISABLE;
        else if (pick < 6)
            op = OP_RECOVER;
        else if (pick < 8)
            op = $urandom_range(0, 1) ? OP_MODE_SILENT : OP_MODE_NORMAL;
        else if (pick < 11)
            op = 4'(OP_TEST_ON) + 4'($urandom_range(0, 2));
        else if (pick < 13)
            op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        if (pick >= 95) begin
            b.opcode = 4'($urandom_range(0, 15));
            b.now_ms = clock_ms;
            b.first_sample = 4'($urandom);
            b.recheck_samples = {8'($urandom), 32'($urandom)};
        end else if (intrusion) begin
            b = build_beat(op, $urandom_range(0, 9) == 0, $urandom_range(2, RECHECK_COUNT));
        end else begin
            b = build_beat(op, $urandom_range(0, 3) != 0, $urandom_range(0, 3));
        end
        return b;
    endfunction

    task automatic send_beat(t_in_item beat);
        @(negedge i_clk);
        in_if.valid <= 1'b1;
        in_if.data <= beat;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        expected_beats.push_back(predict_beat(beat));
    endtask

    task automatic send_op(logic [3:0] op, logic first_good, int misses, int step);
        clock_ms = clock_ms + TIME_W'(step);
        send_beat(build_beat(op, first_good, misses));
    endtask

    task automatic pause_sender(int cycles);
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic wait_drain();
        pause_sender(1);
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_reg(t_cfg_idx idx, logic [DUR_W-1:0] value);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_RING_TIME:   ring_ms = value;
            CFG_SHORT_PAUSE: short_ms = value;
            CFG_LONG_PAUSE:  long_ms = value;
            CFG_AUTO_REC:    autorec_ms = value;
            CFG_GROUP_SIZE:  group_sz = value[3:0];
            CFG_MAX_RINGS:   ring_limit = value[3:0];
            CFG_LINE_MASK:   watch_mask = value[3:0];
            default:         watch_pat = value[3:0];
        endcase
    endtask

    task automatic program_regs(logic [DUR_W-1:0] ring, logic [DUR_W-1:0] short_p,
                                logic [DUR_W-1:0] long_p, logic [DUR_W-1:0] auto_rec,
                                logic [3:0] group, logic [3:0] rings,
                                logic [3:0] mask, logic [3:0] pattern);
        set_reg(CFG_RING_TIME, ring);
        set_reg(CFG_SHORT_PAUSE, short_p);
        set_reg(CFG_LONG_PAUSE, long_p);
        set_reg(CFG_AUTO_REC, auto_rec);
        set_reg(CFG_GROUP_SIZE, DUR_W'(group));
        set_reg(CFG_MAX_RINGS, DUR_W'(rings));
        set_reg(CFG_LINE_MASK, DUR_W'(mask));
        set_reg(CFG_LINE_PAT, DUR_W'(pattern));
    endtask

    task automatic run_session(int beats);
        int sent;
        int burst;
        sent = 0;
        while (sent < beats) begin
            burst = $urandom_range(1, 8);
            repeat (burst) begin
                send_beat(random_beat());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 12));
        end
    endtask

    // ---------------- tests ----------------
    task automatic test_commands();
        send_beat('0);                          // all-zero tick while disarmed
        send_op(OP_TEST_ON, 1'b1, 0, 1);
        send_op(OP_TEST_TOGGLE, 1'b1, 0, 1);
        send_op(OP_TEST_TOGGLE, 1'b1, 0, 1);
        send_op(OP_MODE_SILENT, 1'b1, 0, 1);
        send_op(OP_TEST_ON, 1'b1, 0, 1);        // muted
        send_op(OP_MODE_NORMAL, 1'b1, 0, 1);    // silent reset, no pulse
        send_op(OP_TEST_OFF, 1'b1, 0, 1);
        send_op(OP_ENABLE, 1'b0, RECHECK_COUNT, 1);      // arming refused
        send_op(OP_ENABLE, 1'b0, ANOMALY_LIMIT, 1);      // at the limit: still good
        send_op(OP_TICK, 1'b0, ANOMALY_LIMIT + 1, 1);    // one over: sounding
        send_op(OP_TICK, 1'b0, RECHECK_COUNT, int'(RING_TIME_RST) + 1);
        send_op(OP_UNUSED_HI, 1'b1, 0, int'(SHORT_PAUSE_RST) + 1);
        send_op(OP_DISABLE, 1'b1, 0, 1);
    endtask

    task automatic test_special_cases();
        // group size zero: every pause is long; auto recovery never fires
        wait_drain();
        program_regs('0, '0, '0, '1, 4'd0, 4'd2, 4'hF, 4'h0);
        send_op(OP_ENABLE, 1'b1, 0, 1);
        repeat (4) send_op(OP_TICK, 1'b0, RECHECK_COUNT, 1);
        send_op(OP_RECOVER, 1'b0, RECHECK_COUNT, 1);
        send_op(OP_TICK, 1'b0, RECHECK_COUNT, 1);
        // pattern outside the mask never matches
        wait_drain();
        set_reg(CFG_LINE_MASK, DUR_W'(4'b0011));
        set_reg(CFG_LINE_PAT, DUR_W'(4'b0100));
        send_op(OP_ENABLE, 1'b1, 0, 1);
        // empty mask: every sample matches
        wait_drain();
        set_reg(CFG_LINE_MASK, '0);
        set_reg(CFG_LINE_PAT, '0);
        send_op(OP_ENABLE, 1'b0, RECHECK_COUNT, 1);
        send_op(OP_DISABLE, 1'b0, RECHECK_COUNT, 1);
        // uptime wraps between ring start and ring end
        wait_drain();
        program_regs(24'd5, 24'd2, 24'd4, 24'd10, 4'd2, 4'd3, 4'hF, 4'h0);
        clock_ms = '1;
        clock_ms = clock_ms - 1;
        send_op(OP_ENABLE, 1'b1, 0, 0);
        clock_ms = '1;
        send_beat(t_in_item'{opcode: OP_TICK, now_ms: '1, first_sample: '1,
                             recheck_samples: '1});
        send_op(OP_TICK, 1'b0, RECHECK_COUNT, 7);
    endtask

    task automatic test_random_sessions();
        for (int s = 0; s < 6; s++) begin
            wait_drain();
            case (s)
                0: begin
                    program_regs(24'd20, 24'd5, 24'd15, 24'd60, 4'd2, 4'd4, 4'hF, 4'h0);
                    step_max = 6;
                end
                1: begin
                    program_regs('0, '0, '0, '0, 4'd1, 4'd1, 4'hF, 4'h5);
                    step_max = 2;
                end
                2: begin
                    program_regs('1, '1, '1, '1, 4'd15, 4'd15, 4'b1010, 4'b1000);
                    step_max = 8_000_000;
                end
                3: begin
                    program_regs(24'd8, 24'd3, 24'd12, 24'd40, 4'd0, 4'd9, 4'b0110, 4'b0010);
                    step_max = 5;
                end
                default: begin
                    step_max = (s == 4) ? 10 : 600;
                    program_regs(24'($urandom_range(0, step_max * 6)),
                                 24'($urandom_range(0, step_max * 6)),
                                 24'($urandom_range(0, step_max * 6)),
                                 24'($urandom_range(0, step_max * 20)),
                                 4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
                end
            endcase
            run_session(110);
        end
    endtask

    // result side holds off long enough that the input must stall
    task automatic test_output_hold();
        hold_len = 300;
        hold_token++;
        repeat (12) send_beat(random_beat());
        wait_drain();
    endtask

    // sender stops until every result is back, then resumes
    task automatic test_drain_pause();
        repeat (10) send_beat(random_beat());
        wait_drain();
        repeat (10) send_beat(random_beat());
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        cfg_we = 1'b0;
        cfg_idx = CFG_RING_TIME;
        cfg_data = '0;
        ring_ms = RING_TIME_RST;
        short_ms = SHORT_PAUSE_RST;
        long_ms = LONG_PAUSE_RST;
        autorec_ms = AUTO_REC_RST;
        group_sz = GROUP_RST;
        ring_limit = MAX_RINGS_RST;
        watch_mask = MASK_RST;
        watch_pat = PATTERN_RST;
        al_state = AL_INACTIVE;
        sr_phase = SP_INIT;
        ring_cnt = '0;
        long_sel = 1'b0;
        phase_t0 = '0;
        recover_t0 = '0;
        armed_q = 1'b0;
        silent_q = 1'b0;
        relay_q = 1'b0;
        recover_req = 1'b0;
        clock_ms = '0;
        intrusion = 1'b0;
        step_max = 6;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_commands();
        test_special_cases();
        test_random_sessions();
        test_output_hold();
        test_drain_pause();

        pause_sender(1);
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("alarm_siren_sequencer: match");
        else
            $display("alarm_siren_sequencer: mismatch");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d result beats outstanding", expected_beats.size());
        $display("alarm_siren_sequencer: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/als_pkg.sv
rtl/als_if.sv
rtl/als_sub.sv
rtl/als_scan.sv
rtl/alarm_siren_sequencer.sv
verif/tb_top.sv
